// File: rtl/mrt_pkg.sv
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared types and constants of the mapped region table.
// ----------------------------------------------------------------------------
package mrt_pkg;

    localparam int SLOTS   = 16;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int PASS_W  = $clog2(SLOTS + 1);
    localparam int AW      = 39;
    localparam int PG_W    = 12;
    localparam int OFF_W   = 33;
    localparam int BS_W    = 32;
    localparam int FILL_W  = 13;
    localparam int CFG_W   = 2;

    localparam logic [AW-1:0]     TOP_RST    = AW'(64'h40_0000_0000);
    localparam logic [FILL_W-1:0] PAGE_BYTES = FILL_W'(4096);
    localparam logic [OFF_W-1:0]  OFF_SAT    = OFF_W'(64'h1_0000_0000);

    localparam logic [CFG_W-1:0] CFG_HEAP_SIZE   = CFG_W'(0);
    localparam logic [CFG_W-1:0] CFG_MMAP_TOP    = CFG_W'(1);
    localparam logic [CFG_W-1:0] CFG_MAX_USER_VA = CFG_W'(2);

    typedef enum logic [1:0] {
        OP_MAP, OP_FAULT, OP_UNMAP, OP_LIMIT
    } t_op;

    typedef enum logic [2:0] {
        ST_OK, ST_BAD_ARGS, ST_NO_SLOT, ST_NO_SPACE, ST_NOT_FOUND, ST_DENIED, ST_OFF_OVF
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_PASS, S_RD, S_EV, S_SPARE, S_END
    } t_fsm;

    typedef struct packed {
        logic [AW-1:0]    start;
        logic [AW-1:0]    rend;
        logic [AW-1:0]    vend;
        logic [OFF_W-1:0] offset;
        logic [2:0]       prot;
        logic             shared;
    } t_region;

    localparam int REC_W = $bits(t_region);

endpackage

// File: rtl/mrt_ram.sv
// ----------------------------------------------------------------------------
// mrt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/mapped_region_table_core.sv
// A map makes up to SLOTS+1 gap passes over the table. An unmap scans the table once
// to find overlaps and, unless nothing overlaps or no slot is free for a split, once
// more to cut them. One transaction at a time; each slot is read in S_RD and then
// evaluated in S_EV.
// Result strobe o_valid lasts one cycle and cannot be stalled.
// Synchronous active-low reset empties the table and loads register defaults.
// ----------------------------------------------------------------------------
// mapped_region_table_core
// Table of mapped regions: top-down map, fault lookup, unmap, heap limit.
// ----------------------------------------------------------------------------
module mapped_region_table_core import mrt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_idx,
    input  logic [AW-1:0]     i_cfg_data,
    input  logic [1:0]        i_op,
    input  logic [AW-1:0]     i_addr,
    input  logic [AW-1:0]     i_length,
    input  logic [2:0]        i_prot,
    input  logic [1:0]        i_sharing,
    input  logic [BS_W-1:0]   i_backing_start,
    input  logic [1:0]        i_access,
    output logic              o_valid,
    output logic [2:0]        o_status,
    output logic [AW-1:0]     o_result_addr,
    output logic [IDX_W-1:0]  o_slot,
    output logic [BS_W-1:0]   o_backing_offset,
    output logic [FILL_W-1:0] o_fill_length,
    output logic [2:0]        o_page_perm,
    output logic              o_is_shared
);

    localparam logic [1:0] SHR_PRIVATE = 2'b01;
    localparam logic [1:0] SHR_SHARED  = 2'b10;
    localparam logic [1:0] ACC_READ    = 2'd0;
    localparam logic [1:0] ACC_WRITE   = 2'd1;
    localparam logic [1:0] ACC_EXEC    = 2'd2;
    localparam logic [AW:0] PG_MASK    = (AW+1)'((1 << PG_W) - 1);

    function automatic logic [OFF_W-1:0] offadd(input logic [OFF_W-1:0] base,
                                                input logic [AW-1:0] delta);
        logic [AW:0] s;
        s = {{(AW+1-OFF_W){1'b0}}, base} + {1'b0, delta};
        offadd = (s >= {{(AW+1-OFF_W){1'b0}}, OFF_SAT}) ? OFF_SAT : s[OFF_W-1:0];
    endfunction

    t_fsm r_state, n_state;
    logic [AW-1:0] r_heap, r_top, r_maxva;
    t_op r_op, n_op;
    logic [AW-1:0] r_addr, n_addr, r_len, n_len;
    logic [2:0] r_prot, n_prot;
    logic [1:0] r_shr, n_shr, r_acc, n_acc;
    logic [BS_W-1:0] r_bstart, n_bstart;
    logic [SLOTS-1:0] r_used, n_used;
    logic [IDX_W-1:0] r_idx, n_idx, r_hit_idx, n_hit_idx, r_slot, n_slot;
    logic r_phase, n_phase, r_found, n_found, r_split, n_split;
    logic r_spare_ok, n_spare_ok, r_lo_wrap, n_lo_wrap;
    t_region r_rec, n_rec;
    logic [AW-1:0] r_best, n_best, r_gtop, n_gtop, r_lo, n_lo, r_limit, n_limit;
    logic [AW:0] r_mlen, n_mlen, r_bottom, n_bottom, r_uend, n_uend;
    logic [PASS_W-1:0] r_pass, n_pass;

    logic r_valid;
    logic [2:0] r_o_status;
    logic [AW-1:0] r_o_addr;
    logic [IDX_W-1:0] r_o_slot;
    logic [BS_W-1:0] r_o_off;
    logic [FILL_W-1:0] r_o_fill;
    logic [2:0] r_o_perm;
    logic r_o_sh;

    logic fin;
    t_status f_status;
    logic [AW-1:0] f_addr;
    logic [IDX_W-1:0] f_slot;
    logic [BS_W-1:0] f_off;
    logic [FILL_W-1:0] f_fill;
    logic [2:0] f_perm;
    logic f_sh;

    logic ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_region ram_wdata;
    logic [REC_W-1:0] ram_rdata;
    t_region rec;

    logic [IDX_W-1:0] free_idx;
    logic any_free;
    logic u, last;
    logic map_bad, no_gap_base, pass_go, lo_wrap;
    logic [AW:0] mlen_c, bottom_c, gtop_e, um_sum, um_end;
    logic [AW+1:0] lo_diff;
    logic um_bad, um_end_bad;
    logic map_hit, flt_hit, um_hit, um_split, um_full, um_head, um_tail, do_spare;
    logic [AW-1:0] um_lo, um_hi, vend_cut;
    logic [OFF_W-1:0] off_new;
    logic [AW-1:0] page;
    logic acc_ok;
    logic [AW:0] f_delta, f_sum, f_vd;
    logic f_ovf;
    logic [FILL_W-1:0] fill_c;

    mrt_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rec  = t_region'(ram_rdata);
    assign busy = (r_state != S_IDLE);
    assign u    = r_used[r_idx];
    assign last = (r_idx == IDX_W'(SLOTS - 1));

    always_comb begin
        free_idx = '0;
        any_free = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_idx = IDX_W'(i);
                any_free = 1'b1;
            end
        end
    end

    // argument checks
    assign map_bad = (r_addr != '0) || (r_len == '0) || (r_len > r_top)
                     || (r_prot[1] && !r_prot[0])
                     || !((r_shr == SHR_PRIVATE) || (r_shr == SHR_SHARED));
    assign mlen_c      = ({1'b0, r_len} + PG_MASK) & ~PG_MASK;
    assign bottom_c    = ({1'b0, r_heap} + PG_MASK) & ~PG_MASK;
    assign no_gap_base = bottom_c > {1'b0, r_top};
    assign gtop_e      = {1'b0, r_gtop};
    assign pass_go     = (r_pass <= PASS_W'(SLOTS))
                         && ((gtop_e < r_bottom) || (r_mlen <= gtop_e - r_bottom));
    assign lo_diff     = {1'b0, gtop_e} - {1'b0, r_mlen};
    assign lo_wrap     = lo_diff[AW+1];

    assign um_bad = (r_len == '0) || (r_addr[PG_W-1:0] != '0) || (r_addr >= r_top)
                    || (r_len > r_top - r_addr);
    assign um_sum     = {1'b0, r_addr} + {1'b0, r_len};
    assign um_end     = (um_sum + PG_MASK) & ~PG_MASK;
    assign um_end_bad = um_end > {1'b0, r_top};

    // per-entry evaluation
    assign map_hit  = u && !r_lo_wrap && (r_lo < rec.rend) && (rec.start < r_gtop);
    assign flt_hit  = u && (rec.start <= r_addr) && (r_addr < rec.rend);
    assign um_hit   = u && (r_addr < rec.rend) && ({1'b0, rec.start} < r_uend);
    assign um_split = (rec.start < r_addr) && (r_uend < {1'b0, rec.rend});
    assign um_lo    = (r_addr > rec.start) ? r_addr : rec.start;
    assign um_hi    = (r_uend < {1'b0, rec.rend}) ? r_uend[AW-1:0] : rec.rend;
    assign um_head  = (um_lo == rec.start);
    assign um_tail  = (um_hi == rec.rend);
    assign um_full  = um_head && um_tail;
    assign vend_cut = (rec.vend > um_lo) ? um_lo : rec.vend;
    assign off_new  = offadd(rec.offset, um_hi - rec.start);
    assign do_spare = (r_state == S_EV) && (r_op == OP_UNMAP) && r_phase && um_hit
                      && !um_head && !um_tail && r_spare_ok;

    // fault result
    assign page = {r_addr[AW-1:PG_W], PG_W'(0)};
    always_comb begin
        case (r_acc)
            ACC_READ:  acc_ok = r_rec.prot[0];
            ACC_WRITE: acc_ok = r_rec.prot[1];
            ACC_EXEC:  acc_ok = r_rec.prot[2];
            default:   acc_ok = 1'b0;
        endcase
    end
    assign f_delta = {1'b0, page} - {1'b0, r_rec.start};
    assign f_sum   = {{(AW+1-OFF_W){1'b0}}, r_rec.offset} + {1'b0, f_delta[AW-1:0]};
    assign f_ovf   = f_delta[AW] || (f_sum[AW:BS_W] != '0);
    assign f_vd    = {1'b0, r_rec.vend} - {1'b0, page};
    assign fill_c  = f_vd[AW] ? '0
                   : (f_vd[AW-1:0] >= AW'(PAGE_BYTES)) ? PAGE_BYTES : f_vd[FILL_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_CHECK;
            end
            S_CHECK: begin
                unique case (r_op)
                    OP_MAP:   n_state = (map_bad || !any_free || no_gap_base) ? S_IDLE : S_PASS;
                    OP_FAULT: n_state = (r_addr >= r_maxva) ? S_IDLE : S_RD;
                    OP_UNMAP: n_state = (um_bad || um_end_bad) ? S_IDLE : S_RD;
                    default:  n_state = S_RD;
                endcase
            end
            S_PASS:  n_state = pass_go ? S_RD : S_IDLE;
            S_RD:    n_state = S_EV;
            S_EV:    n_state = do_spare ? S_SPARE : (last ? S_END : S_RD);
            S_SPARE: n_state = last ? S_END : S_RD;
            S_END: begin
                if ((r_op == OP_MAP) && r_found) begin
                    n_state = S_PASS;
                end else if ((r_op == OP_UNMAP) && !r_phase && r_found
                             && !(r_split && !any_free)) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op = r_op; n_addr = r_addr; n_len = r_len; n_prot = r_prot; n_shr = r_shr;
        n_bstart = r_bstart; n_acc = r_acc;
        n_used = r_used; n_idx = r_idx; n_hit_idx = r_hit_idx; n_slot = r_slot;
        n_phase = r_phase; n_found = r_found; n_split = r_split;
        n_spare_ok = r_spare_ok; n_lo_wrap = r_lo_wrap; n_rec = r_rec;
        n_best = r_best; n_gtop = r_gtop; n_lo = r_lo; n_limit = r_limit;
        n_mlen = r_mlen; n_bottom = r_bottom; n_uend = r_uend; n_pass = r_pass;
        ram_we = 1'b0; ram_waddr = r_idx; ram_wdata = rec;
        fin = 1'b0; f_status = ST_OK; f_addr = '0; f_slot = '0; f_off = '0;
        f_fill = '0; f_perm = '0; f_sh = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op = t_op'(i_op); n_addr = i_addr; n_len = i_length;
                    n_prot = i_prot; n_shr = i_sharing;
                    n_bstart = i_backing_start; n_acc = i_access;
                end
            end
            S_CHECK: begin
                n_idx = '0; n_found = 1'b0;
                unique case (r_op)
                    OP_MAP: begin
                        if (map_bad) begin
                            fin = 1'b1; f_status = ST_BAD_ARGS;
                        end else if (!any_free) begin
                            fin = 1'b1; f_status = ST_NO_SLOT;
                        end else if (no_gap_base) begin
                            fin = 1'b1; f_status = ST_NO_SPACE;
                        end
                        n_mlen = mlen_c; n_bottom = bottom_c; n_gtop = r_top;
                        n_pass = '0; n_slot = free_idx;
                    end
                    OP_FAULT: begin
                        if (r_addr >= r_maxva) begin
                            fin = 1'b1; f_status = ST_NOT_FOUND;
                        end
                    end
                    OP_UNMAP: begin
                        if (um_bad || um_end_bad) begin
                            fin = 1'b1; f_status = ST_BAD_ARGS;
                        end
                        n_uend = um_end; n_phase = 1'b0; n_split = 1'b0;
                    end
                    default: n_limit = r_top;
                endcase
            end
            S_PASS: begin
                if (pass_go) begin
                    n_lo = lo_diff[AW-1:0]; n_lo_wrap = lo_wrap;
                    n_found = 1'b0; n_idx = '0;
                end else begin
                    fin = 1'b1; f_status = ST_NO_SPACE;
                end
            end
            S_RD: begin
            end
            S_EV: begin
                if (!do_spare) n_idx = r_idx + IDX_W'(1);
                unique case (r_op)
                    OP_MAP: begin
                        if (map_hit && (!r_found || rec.start > r_best)) begin
                            n_found = 1'b1; n_best = rec.start;
                        end
                    end
                    OP_FAULT: begin
                        if (flt_hit && !r_found) begin
                            n_found = 1'b1; n_hit_idx = r_idx; n_rec = rec;
                        end
                    end
                    OP_UNMAP: begin
                        if (!r_phase) begin
                            if (um_hit) begin
                                n_found = 1'b1;
                                if (um_split) n_split = 1'b1;
                            end
                        end else if (um_hit) begin
                            if (um_full) begin
                                n_used[r_idx] = 1'b0;
                            end else if (um_head) begin
                                ram_we = 1'b1;
                                ram_wdata.start = um_hi;
                                ram_wdata.offset = off_new;
                            end else if (um_tail) begin
                                ram_we = 1'b1;
                                ram_wdata.rend = um_lo;
                                ram_wdata.vend = vend_cut;
                            end else if (r_spare_ok) begin
                                ram_we = 1'b1;
                                ram_wdata.rend = um_lo;
                                ram_wdata.vend = vend_cut;
                                n_rec = rec;
                                n_rec.start = um_hi;
                                n_rec.offset = off_new;
                                n_spare_ok = 1'b0;
                            end
                        end
                    end
                    default: begin
                        if (u && rec.start < r_limit) n_limit = rec.start;
                    end
                endcase
            end
            S_SPARE: begin
                ram_we = 1'b1; ram_waddr = r_slot; ram_wdata = r_rec;
                n_used[r_slot] = 1'b1;
                n_idx = r_idx + IDX_W'(1);
            end
            S_END: begin
                unique case (r_op)
                    OP_MAP: begin
                        if (r_found) begin
                            n_gtop = r_best; n_pass = r_pass + PASS_W'(1);
                        end else begin
                            ram_we = 1'b1; ram_waddr = r_slot;
                            // a start that wrapped below zero sits above every range
                            ram_wdata.start  = r_lo_wrap ? '1 : r_lo;
                            ram_wdata.rend   = r_lo + r_mlen[AW-1:0];
                            ram_wdata.vend   = r_lo + r_len;
                            ram_wdata.offset = {1'b0, r_bstart};
                            ram_wdata.prot   = r_prot;
                            ram_wdata.shared = (r_shr == SHR_SHARED);
                            n_used[r_slot] = 1'b1;
                            fin = 1'b1; f_addr = r_lo; f_slot = r_slot;
                        end
                    end
                    OP_FAULT: begin
                        fin = 1'b1;
                        if (!r_found) begin
                            f_status = ST_NOT_FOUND;
                        end else if (!acc_ok) begin
                            f_status = ST_DENIED; f_addr = page; f_slot = r_hit_idx;
                        end else if (f_ovf) begin
                            f_status = ST_OFF_OVF; f_addr = page; f_slot = r_hit_idx;
                        end else begin
                            f_addr = page; f_slot = r_hit_idx;
                            f_off = f_sum[BS_W-1:0]; f_fill = fill_c;
                            f_perm = r_rec.prot; f_sh = r_rec.shared;
                        end
                    end
                    OP_UNMAP: begin
                        if (r_phase) begin
                            fin = 1'b1;
                        end else if (!r_found) begin
                            fin = 1'b1; f_status = ST_NOT_FOUND;
                        end else if (r_split && !any_free) begin
                            fin = 1'b1; f_status = ST_NO_SLOT;
                        end else begin
                            n_slot = free_idx; n_spare_ok = r_split;
                            n_phase = 1'b1; n_idx = '0;
                        end
                    end
                    default: begin
                        fin = 1'b1; f_addr = r_limit;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_heap  <= '0;
            r_top   <= TOP_RST;
            r_maxva <= TOP_RST;
            r_used  <= '0;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_valid <= fin;
            r_idx   <= n_idx;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_HEAP_SIZE:   r_heap  <= i_cfg_data;
                    CFG_MMAP_TOP:    r_top   <= i_cfg_data;
                    CFG_MAX_USER_VA: r_maxva <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_addr <= n_addr; r_len <= n_len; r_prot <= n_prot;
        r_shr <= n_shr; r_bstart <= n_bstart; r_acc <= n_acc;
        r_hit_idx <= n_hit_idx; r_slot <= n_slot; r_phase <= n_phase;
        r_found <= n_found; r_split <= n_split; r_spare_ok <= n_spare_ok;
        r_lo_wrap <= n_lo_wrap; r_rec <= n_rec; r_best <= n_best;
        r_gtop <= n_gtop; r_lo <= n_lo; r_limit <= n_limit; r_mlen <= n_mlen;
        r_bottom <= n_bottom; r_uend <= n_uend; r_pass <= n_pass;
        if (fin) begin
            r_o_status <= f_status;
            r_o_addr   <= f_addr;
            r_o_slot   <= f_slot;
            r_o_off    <= f_off;
            r_o_fill   <= f_fill;
            r_o_perm   <= f_perm;
            r_o_sh     <= f_sh;
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_o_status;
    assign o_result_addr    = r_o_addr;
    assign o_slot           = r_o_slot;
    assign o_backing_offset = r_o_off;
    assign o_fill_length    = r_o_fill;
    assign o_page_perm      = r_o_perm;
    assign o_is_shared      = r_o_sh;

endmodule

// File: rtl/mrt_checker.sv
// ----------------------------------------------------------------------------
// mrt_checker
// Port-level checks on transaction sequencing and result fields.
// ----------------------------------------------------------------------------
module mrt_checker import mrt_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic [2:0]        o_status,
    input logic [AW-1:0]     o_result_addr,
    input logic [IDX_W-1:0]  o_slot,
    input logic [FILL_W-1:0] o_fill_length
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted transaction without busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while still busy");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fill_length <= PAGE_BYTES)) else $error("fill length above a page");

    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_NOT_FOUND)) |-> ((o_result_addr == '0) && (o_slot == '0)))
        else $error("not-found result carries data");

endmodule

bind mapped_region_table_core mrt_checker u_mrt_checker (.*);
